// ===== rtl/core/dura_pkg.sv =====
package dura_pkg;

    // default width of the echo tick counter
    localparam int TIMER_BITS_DEF = 16;

    // configuration register indexes
    localparam logic [2:0] CFG_TRIGGER_TICKS = 3'd0;
    localparam logic [2:0] CFG_SCALE_Q16     = 3'd1;
    localparam logic [2:0] CFG_NEAR_LIMIT    = 3'd2;
    localparam logic [2:0] CFG_MID_LIMIT     = 3'd3;
    localparam logic [2:0] CFG_FAR_LIMIT     = 3'd4;
    localparam logic [2:0] CFG_PAUSE_TICKS   = 3'd5;

    // configuration reset values
    localparam logic [7:0]  TRIGGER_TICKS_RST = 8'd11;
    localparam logic [15:0] SCALE_Q16_RST     = 16'd1219;
    localparam logic [15:0] NEAR_LIMIT_RST    = 16'd20;
    localparam logic [15:0] MID_LIMIT_RST     = 16'd50;
    localparam logic [15:0] FAR_LIMIT_RST     = 16'd100;
    localparam logic [19:0] PAUSE_TICKS_RST   = 20'd184332;

    // measurement sequencer phases
    localparam logic [2:0] PH_TRIG_L = 3'd0;
    localparam logic [2:0] PH_WAIT_L = 3'd1;
    localparam logic [2:0] PH_CNT_L  = 3'd2;
    localparam logic [2:0] PH_TRIG_R = 3'd3;
    localparam logic [2:0] PH_WAIT_R = 3'd4;
    localparam logic [2:0] PH_CNT_R  = 3'd5;
    localparam logic [2:0] PH_PAUSE  = 3'd6;

    // alert zone codes
    localparam logic [1:0] ZONE_NONE   = 2'd0;
    localparam logic [1:0] ZONE_GREEN  = 2'd1;
    localparam logic [1:0] ZONE_YELLOW = 2'd2;
    localparam logic [1:0] ZONE_RED    = 2'd3;

    // one result beat
    typedef struct packed {
        logic        left_trig;
        logic        right_trig;
        logic [1:0]  alert_zone;
        logic [15:0] left_cm;
        logic [15:0] right_cm;
        logic        cycle_done;
    } result_t;

endpackage

// ===== rtl/core/dual_ultrasonic_range_alert_top.sv =====
// Dual ultrasonic range alert. Each input beat is one timer tick with the two echo pin
// levels; the block takes one beat every clock while the skid register is empty and
// returns one registered result beat per input beat. A two-entry output stage (result
// register plus skid register) keeps input acceptance going while a result waits.
// The sequencer pulses the left trigger, times the left echo with a TIMER_BITS wide
// counter that saturates on timeout, then does the same on the right and pauses.
// Echo ticks become centimetres as (ticks * scale_q16) >> 16, saturated to 16 bits;
// that multiply and the zone compares against the nearer distance set the critical
// path, all combinational between the state registers and the result register.
// Configuration registers are written through a plain write port with no wait state.
module dual_ultrasonic_range_alert_top #(
    parameter int TIMER_BITS = dura_pkg::TIMER_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [19:0] cfg_wdata,
    // tick input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_echo_left,
    input  logic        s_echo_right,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_left_trig,
    output logic        m_right_trig,
    output logic [1:0]  m_alert_zone,
    output logic [15:0] m_left_cm,
    output logic [15:0] m_right_cm,
    output logic        m_cycle_done
);

    localparam int PW = TIMER_BITS + 16;

    // configuration registers
    logic [7:0]  trigger_ticks_reg;
    logic [15:0] scale_q16_reg;
    logic [15:0] near_limit_reg;
    logic [15:0] mid_limit_reg;
    logic [15:0] far_limit_reg;
    logic [19:0] pause_ticks_reg;

    // sequencer state
    logic [2:0]            phase_reg, phase_next;
    logic [TIMER_BITS-1:0] tick_count_reg, tick_count_next;
    logic [19:0]           pause_count_reg, pause_count_next;
    logic [15:0]           left_dist_reg, left_dist_next;
    logic [15:0]           right_dist_reg, right_dist_next;
    logic [1:0]            zone_reg, zone_next;
    logic                  done_c;

    // output stage
    logic              out_valid_reg;
    logic              skid_valid_reg;
    dura_pkg::result_t out_reg;
    dura_pkg::result_t skid_reg;
    dura_pkg::result_t result_c;

    logic s_fire;
    logic out_free;

    // distance datapath
    logic [TIMER_BITS-1:0] tick_inc;
    logic [PW-1:0]         prod;
    logic [PW+15:0]        prod_ext;
    logic [15:0]           dist_cm;
    logic [15:0]           near_cm;
    logic [1:0]            zone_pick;

    assign s_ready  = !skid_valid_reg;
    assign s_fire   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    // configuration write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trigger_ticks_reg <= dura_pkg::TRIGGER_TICKS_RST;
            scale_q16_reg     <= dura_pkg::SCALE_Q16_RST;
            near_limit_reg    <= dura_pkg::NEAR_LIMIT_RST;
            mid_limit_reg     <= dura_pkg::MID_LIMIT_RST;
            far_limit_reg     <= dura_pkg::FAR_LIMIT_RST;
            pause_ticks_reg   <= dura_pkg::PAUSE_TICKS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                dura_pkg::CFG_TRIGGER_TICKS: trigger_ticks_reg <= cfg_wdata[7:0];
                dura_pkg::CFG_SCALE_Q16:     scale_q16_reg     <= cfg_wdata[15:0];
                dura_pkg::CFG_NEAR_LIMIT:    near_limit_reg    <= cfg_wdata[15:0];
                dura_pkg::CFG_MID_LIMIT:     mid_limit_reg     <= cfg_wdata[15:0];
                dura_pkg::CFG_FAR_LIMIT:     far_limit_reg     <= cfg_wdata[15:0];
                dura_pkg::CFG_PAUSE_TICKS:   pause_ticks_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // tick count to centimetres, saturated to 16 bits
    assign tick_inc = tick_count_reg + TIMER_BITS'(1);
    assign prod     = PW'(tick_count_reg) * PW'(scale_q16_reg);
    assign prod_ext = {16'b0, prod};
    assign dist_cm  = (|prod_ext[PW+15:32]) ? 16'hFFFF : prod_ext[31:16];

    // nearer distance picks the zone
    assign near_cm = (left_dist_reg < dist_cm) ? left_dist_reg : dist_cm;

    always_comb begin
        if (near_cm < near_limit_reg) begin
            zone_pick = dura_pkg::ZONE_RED;
        end else if (near_cm < mid_limit_reg) begin
            zone_pick = dura_pkg::ZONE_YELLOW;
        end else if (near_cm <= far_limit_reg) begin
            zone_pick = dura_pkg::ZONE_GREEN;
        end else begin
            zone_pick = dura_pkg::ZONE_NONE;
        end
    end

    // measurement sequencer
    always_comb begin
        phase_next       = phase_reg;
        tick_count_next  = tick_count_reg;
        pause_count_next = pause_count_reg;
        left_dist_next   = left_dist_reg;
        right_dist_next  = right_dist_reg;
        zone_next        = zone_reg;
        done_c           = 1'b0;
        unique case (phase_reg)
            dura_pkg::PH_TRIG_L, dura_pkg::PH_TRIG_R: begin
                tick_count_next = tick_inc;
                if (tick_inc >= TIMER_BITS'(trigger_ticks_reg)) begin
                    tick_count_next = '0;
                    phase_next = (phase_reg == dura_pkg::PH_TRIG_L) ?
                                 dura_pkg::PH_WAIT_L : dura_pkg::PH_WAIT_R;
                end
            end
            dura_pkg::PH_WAIT_L: begin
                if (s_echo_left) begin
                    tick_count_next = '0;
                    phase_next = dura_pkg::PH_CNT_L;
                end
            end
            dura_pkg::PH_WAIT_R: begin
                if (s_echo_right) begin
                    tick_count_next = '0;
                    phase_next = dura_pkg::PH_CNT_R;
                end
            end
            dura_pkg::PH_CNT_L: begin
                // echo fall or counter timeout ends the measurement
                if (!s_echo_left || (&tick_count_reg)) begin
                    left_dist_next  = dist_cm;
                    tick_count_next = '0;
                    phase_next      = dura_pkg::PH_TRIG_R;
                end else begin
                    tick_count_next = tick_inc;
                end
            end
            dura_pkg::PH_CNT_R: begin
                if (!s_echo_right || (&tick_count_reg)) begin
                    right_dist_next  = dist_cm;
                    tick_count_next  = '0;
                    zone_next        = zone_pick;
                    done_c           = 1'b1;
                    pause_count_next = '0;
                    phase_next       = dura_pkg::PH_PAUSE;
                end else begin
                    tick_count_next = tick_inc;
                end
            end
            dura_pkg::PH_PAUSE: begin
                pause_count_next = pause_count_reg + 20'd1;
                if (pause_count_next >= pause_ticks_reg) begin
                    pause_count_next = '0;
                    phase_next = dura_pkg::PH_TRIG_L;
                end
            end
            default: begin
                tick_count_next  = '0;
                pause_count_next = '0;
                phase_next       = dura_pkg::PH_TRIG_L;
            end
        endcase
    end

    // result beat for this tick
    always_comb begin
        result_c.left_trig  = (phase_reg == dura_pkg::PH_TRIG_L);
        result_c.right_trig = (phase_reg == dura_pkg::PH_TRIG_R);
        result_c.alert_zone = zone_next;
        result_c.left_cm    = left_dist_next;
        result_c.right_cm   = right_dist_next;
        result_c.cycle_done = done_c;
    end

    // state advances on each accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= dura_pkg::PH_TRIG_L;
            tick_count_reg  <= '0;
            pause_count_reg <= '0;
            left_dist_reg   <= '0;
            right_dist_reg  <= '0;
            zone_reg        <= dura_pkg::ZONE_NONE;
        end else if (s_fire) begin
            phase_reg       <= phase_next;
            tick_count_reg  <= tick_count_next;
            pause_count_reg <= pause_count_next;
            left_dist_reg   <= left_dist_next;
            right_dist_reg  <= right_dist_next;
            zone_reg        <= zone_next;
        end
    end

    // output register and skid control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                out_valid_reg  <= skid_valid_reg || s_fire;
                skid_valid_reg <= 1'b0;
            end else if (s_fire) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_reg <= skid_valid_reg ? skid_reg : result_c;
        end
        if (!out_free && s_fire) begin
            skid_reg <= result_c;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_left_trig  = out_reg.left_trig;
    assign m_right_trig = out_reg.right_trig;
    assign m_alert_zone = out_reg.alert_zone;
    assign m_left_cm    = out_reg.left_cm;
    assign m_right_cm   = out_reg.right_cm;
    assign m_cycle_done = out_reg.cycle_done;

`ifndef ASSERT_OFF
    // skid holds a beat only behind a full output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid beat without output beat");

    // the two triggers are never driven together
    a_trig_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_left_trig && m_right_trig))
        else $error("both triggers driven");

    // a finished cycle always enters the pause
    a_done_to_pause: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && done_c) |=> (phase_reg == dura_pkg::PH_PAUSE))
        else $error("cycle end did not enter pause");
`endif

endmodule
